[hdl/stq_pkg.sv]
// Shared types and constants of the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

    // Number of timer slots in the pool.
    localparam int SLOTS  = 16;
    localparam int IDX_W  = 4;
    localparam int TIME_W = 48;
    localparam int STAMP_W = 32;
    localparam int CNT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               start;
        logic               stop;
        logic               snap;
        logic               fire;
        logic [IDX_W-1:0]   slot;
        logic [IDX_W-1:0]   fire_slot;
        logic [STAMP_W-1:0] stamp;
        logic [TIME_W-1:0]  now;
        logic [31:0]        interval;
        logic               periodic;
        logic               pass_flag;
        logic [63:0]        param;
        logic [15:0]        evt_num;
        logic [7:0]         dest_thr;
    } cell_cmd_t;

    // Candidate passed along the chain: earliest due slot seen so far.
    typedef struct packed {
        logic               valid;
        logic [TIME_W-1:0]  expiry;
        logic [STAMP_W-1:0] stamp;
        logic               reload;
        logic [IDX_W-1:0]   slot;
        logic [15:0]        evt_num;
        logic [7:0]         dest_thr;
        logic               pass_flag;
        logic [63:0]        param;
    } cand_t;

endpackage
`default_nettype wire

[hdl/sorted_software_timer_queue.sv]
// Top level: timer slot chain and the tick sequencer.
// Start, stop and unused beats are taken in the idle state; the block stays ready for the next beat.
// A tick snapshots the due set, then for each fired slot scans the chain, picks the earliest
// and sends an output beat, which m_tready may stall; with nothing due the pick returns to idle.
// Results leave one at a time from the output register; no input is taken meanwhile.
// Synchronous active-low reset clears the time, stamp counter and all active marks.
`timescale 1ns / 1ps
`default_nettype none
module sorted_software_timer_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot[3:0], interval_ms[35:4], periodic[36], pass_flag[37], param[101:38],
    // evt_num[117:102], dest_thr[125:118], zero[127:126]
    input  wire logic [127:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // fired_slot[3:0], fired_event[19:4], fired_thread[27:20],
    // fired_flag[28], fired_param[92:29], zero[95:93]
    output logic [95:0]       m_tdata,
    // last_of_tick
    output logic              m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SNAP = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_PICK = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [stq_pkg::TIME_W-1:0]      now_reg;
    logic [stq_pkg::STAMP_W-1:0]     order_reg;
    logic [stq_pkg::CNT_W-1:0]       cnt_reg;
    logic [95:0]                     data_reg;
    logic                            last_reg;
    stq_pkg::cell_cmd_t              cmd;
    stq_pkg::cand_t                  chain [stq_pkg::SLOTS+1];
    logic [stq_pkg::SLOTS-1:0]       due_vec;
    logic [stq_pkg::SLOTS-1:0]       due_rest;
    logic                            in_beat;
    stq_pkg::cand_t                  best;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign best     = chain[stq_pkg::SLOTS];

    // Due slots other than the one being picked now.
    assign due_rest = due_vec & ~(stq_pkg::SLOTS'(1) << best.slot);

    // Command to the cells.
    always_comb begin
        cmd.start     = in_beat && (s_tuser == stq_pkg::OP_START);
        cmd.stop      = in_beat && (s_tuser == stq_pkg::OP_STOP);
        cmd.snap      = (state_reg == ST_SNAP);
        cmd.fire      = (state_reg == ST_PICK) && best.valid;
        cmd.slot      = s_tdata[3:0];
        cmd.fire_slot = best.slot;
        cmd.stamp     = order_reg;
        cmd.now       = now_reg;
        cmd.interval  = s_tdata[35:4];
        cmd.periodic  = s_tdata[36];
        cmd.pass_flag = s_tdata[37];
        cmd.param     = s_tdata[101:38];
        cmd.evt_num   = s_tdata[117:102];
        cmd.dest_thr  = s_tdata[125:118];
    end

    // Row of slot cells; the search candidate enters empty at the head.
    assign chain[0] = '0;
    for (genvar i = 0; i < stq_pkg::SLOTS; i++) begin : g_cell
        stq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (stq_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1]),
            .due      (due_vec[i])
        );
    end

    // Sequencer next state. Every scan walks the full chain so that the
    // candidate at its tail reflects the current due set.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && (s_tuser == stq_pkg::OP_TICK)) state_next = ST_SNAP;
            end
            ST_SNAP: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (cnt_reg == stq_pkg::CNT_W'(stq_pkg::SLOTS - 1)) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                state_next = best.valid ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (m_tready) state_next = last_reg ? ST_IDLE : ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            order_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (in_beat && (s_tuser == stq_pkg::OP_TICK)) begin
                now_reg <= now_reg + stq_pkg::TIME_W'(1);
            end
            if (cmd.start || (cmd.fire && best.reload)) begin
                order_reg <= order_reg + stq_pkg::STAMP_W'(1);
            end
            // Scan counter runs while the candidate walks the chain.
            if (state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + stq_pkg::CNT_W'(1);
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    // Output register; the beat is last when no other slot stays due.
    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            data_reg <= {3'b000, best.param, best.pass_flag, best.dest_thr,
                         best.evt_num, best.slot};
            last_reg <= (due_rest == '0);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // The sequencer never holds a result while taking input.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // A pick with slots still due must find a candidate.
    a_pick_found: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PICK) && (due_vec != '0)) |-> best.valid)
        else $error("chain returned no candidate with slots due");

    // A fired slot leaves the due set on the next cycle.
    a_due_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fire |=> ($countones(due_vec) == $countones($past(due_vec)) - 1))
        else $error("fired slot still due");

endmodule
`default_nettype wire

[hdl/stq_cell.sv]
// One timer slot cell with its stage of the minimum search chain.
`timescale 1ns / 1ps
`default_nettype none
module stq_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [stq_pkg::IDX_W-1:0] cell_idx,
    input  wire stq_pkg::cell_cmd_t        cmd,
    input  wire stq_pkg::cand_t            cand_in,
    output stq_pkg::cand_t                 cand_out,
    output logic                           due
);

    logic                         active_reg;
    logic                         due_reg;
    logic [stq_pkg::TIME_W-1:0]   expiry_reg;
    logic [31:0]                  period_reg;
    logic [stq_pkg::STAMP_W-1:0]  stamp_reg;
    logic [15:0]                  event_reg;
    logic [7:0]                   thread_reg;
    logic                         flag_reg;
    logic [63:0]                  word_reg;
    stq_pkg::cand_t               cand_reg;
    stq_pkg::cand_t               own;
    logic                         hit_start;
    logic                         hit_fire;
    logic                         goes_first;

    assign hit_start = cmd.start && (cmd.slot == cell_idx);
    assign hit_fire  = cmd.fire && (cmd.fire_slot == cell_idx);

    // Control bits of the slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            due_reg    <= 1'b0;
        end else begin
            if (hit_start) begin
                active_reg <= 1'b1;
            end else if (cmd.stop && (cmd.slot == cell_idx)) begin
                active_reg <= 1'b0;
            end else if (hit_fire && (period_reg == 32'd0)) begin
                active_reg <= 1'b0;
            end
            if (cmd.snap) begin
                due_reg <= active_reg && (expiry_reg <= cmd.now);
            end else if (hit_fire) begin
                due_reg <= 1'b0;
            end
        end
    end

    // Slot payload, written on start and on periodic reload.
    always_ff @(posedge aclk) begin
        if (hit_start) begin
            expiry_reg <= cmd.now + stq_pkg::TIME_W'(cmd.interval);
            period_reg <= cmd.periodic ? cmd.interval : 32'd0;
            stamp_reg  <= cmd.stamp;
            event_reg  <= cmd.evt_num;
            thread_reg <= cmd.dest_thr;
            flag_reg   <= cmd.pass_flag;
            word_reg   <= cmd.param;
        end else if (hit_fire && (period_reg != 32'd0)) begin
            expiry_reg <= expiry_reg + stq_pkg::TIME_W'(period_reg);
            stamp_reg  <= cmd.stamp;
        end
    end

    // Chain stage: keep the earlier of the incoming candidate and this slot.
    always_comb begin
        own.valid     = due_reg;
        own.expiry    = expiry_reg;
        own.stamp     = stamp_reg;
        own.reload    = (period_reg != 32'd0);
        own.slot      = cell_idx;
        own.evt_num   = event_reg;
        own.dest_thr  = thread_reg;
        own.pass_flag = flag_reg;
        own.param     = word_reg;
        goes_first = !cand_in.valid || (expiry_reg < cand_in.expiry) ||
                     ((expiry_reg == cand_in.expiry) && (stamp_reg < cand_in.stamp));
    end

    always_ff @(posedge aclk) begin
        cand_reg <= (due_reg && goes_first) ? own : cand_in;
    end

    assign cand_out = cand_reg;
    assign due      = due_reg;

endmodule
`default_nettype wire

[tb/sv/sorted_software_timer_queue_tb.sv]
// Testbench for the sorted timer queue: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module sorted_software_timer_queue_tb;

    // Code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [47:0] TIME_MASK = 48'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 444;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [31:0] interval;
        logic        periodic;
        logic        pass_flag;
        logic [63:0] param;
        logic [15:0] evt_num;
        logic [7:0]  dest_thr;
    } timer_cmd_t;

    typedef struct {
        logic [3:0]  slot;
        logic [15:0] evt_num;
        logic [7:0]  dest_thr;
        logic        pass_flag;
        logic [63:0] param;
        logic        last;
    } expiry_t;

    typedef struct {
        timer_cmd_t cmd;
        bit         typed;
        bit         fires;
        expiry_t    fired;
    } table_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = stq_pkg::OP_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tlast;

    sorted_software_timer_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Clock with a 20 ns period.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the timer pool.
    logic [47:0] now_ms;
    logic [31:0] next_stamp;
    logic        armed [stq_pkg::SLOTS];
    logic [47:0] expiry [stq_pkg::SLOTS];
    logic [31:0] period [stq_pkg::SLOTS];
    logic [31:0] stamp [stq_pkg::SLOTS];
    logic [15:0] ev_of [stq_pkg::SLOTS];
    logic [7:0]  thr_of [stq_pkg::SLOTS];
    logic        flag_of [stq_pkg::SLOTS];
    logic [63:0] word_of [stq_pkg::SLOTS];

    expiry_t pending_q[$];
    int      mismatches = 0;
    int      s_idle_pct = 13;
    int      m_idle_pct = 49;
    int      hold_requests = 0;
    int      quiet_cycles = 0;

    // Apply one command to the shadow pool and return the expiries it causes.
    task automatic advance_timers(input timer_cmd_t c, output expiry_t fired_q[$]);
        bit due [stq_pkg::SLOTS];
        int best;
        expiry_t e;
        fired_q = {};
        case (c.op)
            stq_pkg::OP_START: begin
                expiry[c.slot] = (now_ms + {16'd0, c.interval}) & TIME_MASK;
                period[c.slot] = c.periodic ? c.interval : 32'd0;
                flag_of[c.slot] = c.pass_flag;
                word_of[c.slot] = c.param;
                ev_of[c.slot] = c.evt_num;
                thr_of[c.slot] = c.dest_thr;
                stamp[c.slot] = next_stamp;
                next_stamp = next_stamp + 32'd1;
                armed[c.slot] = 1'b1;
            end
            stq_pkg::OP_STOP: armed[c.slot] = 1'b0;
            stq_pkg::OP_TICK: begin
                now_ms = (now_ms + 48'd1) & TIME_MASK;
                for (int i = 0; i < stq_pkg::SLOTS; i++)
                    due[i] = armed[i] && expiry[i] <= now_ms;
                forever begin
                    best = -1;
                    for (int i = 0; i < stq_pkg::SLOTS; i++) begin
                        if (due[i] && (best < 0 || expiry[i] < expiry[best] ||
                            (expiry[i] == expiry[best] && stamp[i] < stamp[best])))
                            best = i;
                    end
                    if (best < 0) break;
                    due[best] = 0;
                    e.slot = best[3:0];
                    e.evt_num = ev_of[best];
                    e.dest_thr = thr_of[best];
                    e.pass_flag = flag_of[best];
                    e.param = word_of[best];
                    e.last = 1'b0;
                    fired_q.push_back(e);
                    // Periodic slots reload from their old expiry; one-shots disarm.
                    if (period[best] != 0) begin
                        expiry[best] = (expiry[best] + {16'd0, period[best]}) & TIME_MASK;
                        stamp[best] = next_stamp;
                        next_stamp = next_stamp + 32'd1;
                    end else begin
                        armed[best] = 1'b0;
                    end
                end
                if (fired_q.size() > 0) fired_q[fired_q.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(input timer_cmd_t c);
        if ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= {2'b00, c.dest_thr, c.evt_num, c.param, c.pass_flag, c.periodic,
                    c.interval, c.slot};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
    endtask

    // Send one command and queue what it should produce.
    task automatic issue(input timer_cmd_t c, input bit typed, input bit fires,
                         input expiry_t fired);
        expiry_t got_q[$];
        send_beat(c);
        advance_timers(c, got_q);
        if (typed) begin
            if (fires) pending_q.push_back(fired);
        end else begin
            foreach (got_q[i]) pending_q.push_back(got_q[i]);
        end
    endtask

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        c.op = (pick < 45) ? stq_pkg::OP_TICK : (pick < 83) ? stq_pkg::OP_START :
               (pick < 97) ? stq_pkg::OP_STOP : OP_UNUSED;
        c.slot = 4'($urandom_range(15));
        // Mostly short delays so that slots actually come due.
        c.interval = ($urandom_range(19) == 0) ? $urandom : $urandom_range(12);
        c.periodic = 1'($urandom_range(1));
        c.pass_flag = 1'($urandom_range(1));
        c.param = {$urandom, $urandom};
        c.evt_num = 16'($urandom);
        c.dest_thr = 8'($urandom);
        return c;
    endfunction

    // Result side: check each beat, then choose tready for the next edge.
    int held_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            expiry_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: slot %0d last %0b",
                             m_tdata[3:0], m_tlast);
            end else begin
                want = pending_q.pop_front();
                if (m_tdata[3:0] !== want.slot || m_tdata[19:4] !== want.evt_num ||
                    m_tdata[27:20] !== want.dest_thr || m_tdata[28] !== want.pass_flag ||
                    m_tdata[92:29] !== want.param || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want slot %0d ev %h thr %h fl %b par %h last %b",
                                 want.slot, want.evt_num, want.dest_thr, want.pass_flag,
                                 want.param, want.last);
                        $display("          got  slot %0d ev %h thr %h fl %b par %h last %b",
                                 m_tdata[3:0], m_tdata[19:4], m_tdata[27:20], m_tdata[28],
                                 m_tdata[92:29], m_tlast);
                    end
                end
            end
        end
        if (held_seen != hold_requests) begin
            held_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    table_row_t rows [$];

    function automatic table_row_t row(input logic [1:0] op, input int slot,
                                       input logic [31:0] iv, input bit per);
        table_row_t r;
        r.cmd.op = op;
        r.cmd.slot = 4'(slot);
        r.cmd.interval = iv;
        r.cmd.periodic = per;
        r.cmd.pass_flag = slot[0];
        r.cmd.param = {32'hA5A5_0000 | 32'(slot), 32'h0F0F_F0F0};
        r.cmd.evt_num = 16'h1000 + 16'(slot);
        r.cmd.dest_thr = 8'h40 + 8'(slot);
        r.typed = 0;
        r.fires = 0;
        r.fired = '{default: '0};
        return r;
    endfunction

    initial begin
        table_row_t r;
        expiry_t none;
        timer_cmd_t arm;
        now_ms = '0;
        next_stamp = '0;
        for (int i = 0; i < stq_pkg::SLOTS; i++) begin
            armed[i] = 0; expiry[i] = '0; period[i] = '0; stamp[i] = '0;
            ev_of[i] = '0; thr_of[i] = '0; flag_of[i] = 0; word_of[i] = '0;
        end
        none = '{default: '0};

        // Tick straight after reset: nothing is armed, nothing fires.
        r = row(stq_pkg::OP_TICK, 0, 0, 0); r.typed = 1; rows.push_back(r);
        // Zero delay fires on the next tick with the stored data.
        r = row(stq_pkg::OP_START, 0, 0, 0); r.cmd.pass_flag = 0; r.cmd.param = '0;
        r.cmd.evt_num = 16'h0000; r.cmd.dest_thr = 8'h00; r.typed = 1; rows.push_back(r);
        r = row(stq_pkg::OP_TICK, 0, 0, 0); r.typed = 1; r.fires = 1;
        r.fired = '{slot: 4'd0, evt_num: 16'h0, dest_thr: 8'h0, pass_flag: 1'b0,
                    param: 64'h0, last: 1'b1};
        rows.push_back(r);
        // All-ones fields on the top slot with the longest delay.
        r = row(stq_pkg::OP_START, 15, 32'hFFFF_FFFF, 1); r.cmd.pass_flag = 1;
        r.cmd.param = '1; r.cmd.evt_num = '1; r.cmd.dest_thr = '1; rows.push_back(r);
        // Equal expiries: the slot armed first goes first.
        rows.push_back(row(stq_pkg::OP_START, 5, 2, 1));
        rows.push_back(row(stq_pkg::OP_START, 3, 2, 0));
        rows.push_back(row(stq_pkg::OP_STOP, 7, 0, 0));
        r = row(OP_UNUSED, 9, 1, 1); r.typed = 1; rows.push_back(r);
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));
        // Restart of a running slot and a periodic start with zero period.
        rows.push_back(row(stq_pkg::OP_START, 5, 1, 1));
        rows.push_back(row(stq_pkg::OP_START, 8, 0, 1));
        rows.push_back(row(stq_pkg::OP_START, 2, 1, 1));
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));
        rows.push_back(row(stq_pkg::OP_STOP, 5, 0, 0));
        rows.push_back(row(stq_pkg::OP_STOP, 15, 0, 0));
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));
        rows.push_back(row(stq_pkg::OP_STOP, 2, 0, 0));
        rows.push_back(row(stq_pkg::OP_TICK, 0, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].fires, rows[i].fired);

        // Random traffic in three idling phases.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                s_idle_pct = 49; m_idle_pct = 13;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                s_idle_pct = 0; m_idle_pct = 0;
                // Arm every slot to fire, then stall the receiver for a long stretch.
                for (int k = 0; k < stq_pkg::SLOTS; k++) begin
                    arm = random_cmd();
                    arm.op = stq_pkg::OP_START;
                    arm.slot = 4'(k);
                    arm.interval = 32'd1;
                    arm.periodic = 1'b1;
                    issue(arm, 0, 0, none);
                end
                hold_requests++;
            end
            issue(random_cmd(), 0, 0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (3 * stq_pkg::SLOTS + 20) @(posedge aclk);

        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
